/* sv/scaled_time_of_day_calendar_top_macros.svh */
// Assertion macros used by the checker file of the time-of-day calendar.
`ifndef SCALED_TIME_OF_DAY_CALENDAR_TOP_MACROS_SVH
`define SCALED_TIME_OF_DAY_CALENDAR_TOP_MACROS_SVH

// A property that is checked outside reset.
`define STODC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stodc check failed");

// A value that must hold steady in the cycle after a condition.
`define STODC_ASSERT_HOLD(name, clk, rst, cond, sig) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error("stodc value changed while held");

`endif

/* sv/stodc_pkg.sv */
// Types, constants and the month length table of the time-of-day calendar.
package stodc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SCALE,
    ST_DIV_SEC,
    ST_DIV_MIN,
    ST_COMMIT
  } state_t;

  localparam int RATE_W    = 24;
  localparam int ELAPSED_W = 21;
  localparam int POS_W     = 37;
  localparam int PROD_W    = RATE_W + ELAPSED_W;
  localparam int ADV_W     = PROD_W - 4;
  localparam int TOTAL_W   = 17;
  localparam int MOD_W     = 11;
  localparam int DIV_PROD_W = 36;

  localparam logic [POS_W-1:0]  FULL_DAY   = 37'h18_0000_0000;
  localparam logic [POS_W-1:0]  DAY_LAST   = 37'h17_FFFF_FFFF;
  localparam logic [POS_W-1:0]  POS_RESET  = 37'h06_8000_0000;
  localparam logic [11:0]       SEC_PER_HOUR = 12'd3600;
  localparam logic [18:0]       RECIP_60   = 19'd279621;
  localparam logic [RATE_W-1:0] RATE_RESET = 24'd32768;

  localparam logic [5:0] MIN_HALF     = 6'd30;
  localparam logic [5:0] MIN_RESET    = 6'd30;
  localparam logic [4:0] DAY_RESET    = 5'd30;
  localparam logic [3:0] MONTH_RESET  = 4'd11;
  localparam logic [3:0] MONTH_LAST   = 4'd12;
  localparam logic [3:0] MONTH_FEB    = 4'd2;
  localparam logic [6:0] CENTURY_LAST = 7'd99;
  localparam logic [8:0] QUAD_LAST    = 9'd399;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      4'd2:                   days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      default:                days = 5'd31;
    endcase
    if (month == MONTH_FEB && leap) begin
      days = 5'd29;
    end
    return days;
  endfunction

endpackage

/* sv/scaled_time_of_day_calendar_top.sv */
// Top level of the scaled time-of-day calendar with Gregorian date rollover.
//
//   channel | direction | transfer when             | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | sink      | in_valid && !in_stall     | elapsed_time
//   out     | source    | out_valid && !out_stall   | time of day, date, half-hour event
//   cfg     | sink      | cfg_write_enable          | cfg_write_data (hours_per_second)
//
// Each tick runs through these steps from one input transfer to the next: the transfer,
// one multiply, one add and wrap, one scale by 3600, two passes through the shared
// divide-by-60 unit, and one calendar update, which registers the result.
// The result waits in an output register, so a new tick is taken while it is held.
// A held result stalls only the final calendar update of the next tick.
// Reset is synchronous and restores 06:30 on day 30 of month 11, year 2.
module scaled_time_of_day_calendar_top #(
  parameter int YEAR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] elapsed_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_of_year,
  output logic [15:0] year_count,
  output logic        half_hour_event,
  output logic [5:0]  half_hour_slot,
  input  logic        cfg_write_enable,
  input  logic [23:0] cfg_write_data
);

  localparam logic [YEAR_BITS-1:0] YEAR_MAX   = {YEAR_BITS{1'b1}};
  localparam logic [YEAR_BITS-1:0] YEAR_RESET = YEAR_BITS'(2);

  stodc_pkg::state_t state, state_next;

  logic [stodc_pkg::RATE_W-1:0]    rate;
  logic [stodc_pkg::ELAPSED_W-1:0] elapsed;
  logic [stodc_pkg::PROD_W-1:0]    product;
  logic [stodc_pkg::POS_W-1:0]     position;
  logic                            carry;
  logic [stodc_pkg::TOTAL_W-1:0]   total;
  logic [5:0]                      second;
  logic [stodc_pkg::MOD_W-1:0]     minute_of_day;
  logic [5:0]                      minute;
  logic [4:0]                      hour;
  logic [5:0]                      prev_minutes;
  logic [4:0]                      day;
  logic [3:0]                      month;
  logic [YEAR_BITS-1:0]            year;
  logic [6:0]                      year_mod100;
  logic [8:0]                      year_mod400;

  logic commit;
  logic [stodc_pkg::ADV_W-1:0]      advance;
  logic [stodc_pkg::POS_W-1:0]      advance_sat;
  logic [stodc_pkg::POS_W:0]        pos_sum;
  logic [48:0]                      scale_prod;
  logic [stodc_pkg::TOTAL_W-1:0]    div_in;
  logic [stodc_pkg::DIV_PROD_W-1:0] div_prod;
  logic [stodc_pkg::MOD_W-1:0]      div_q;
  logic [stodc_pkg::TOTAL_W-1:0]    div_q60;
  logic [stodc_pkg::TOTAL_W-1:0]    div_rem;
  logic                            leap;
  logic [5:0]                      day_sum;
  logic                            month_over;
  logic                            year_step;
  logic                            event_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stodc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    commit     = 1'b0;
    unique case (state)
      stodc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = stodc_pkg::ST_MUL;
        end
      end
      stodc_pkg::ST_MUL:     state_next = stodc_pkg::ST_ADD;
      stodc_pkg::ST_ADD:     state_next = stodc_pkg::ST_SCALE;
      stodc_pkg::ST_SCALE:   state_next = stodc_pkg::ST_DIV_SEC;
      stodc_pkg::ST_DIV_SEC: state_next = stodc_pkg::ST_DIV_MIN;
      stodc_pkg::ST_DIV_MIN: state_next = stodc_pkg::ST_COMMIT;
      stodc_pkg::ST_COMMIT: begin
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          state_next = stodc_pkg::ST_IDLE;
        end
      end
      default: state_next = stodc_pkg::ST_IDLE;
    endcase
  end

  assign advance     = product[stodc_pkg::PROD_W-1:4];
  assign advance_sat = (advance > stodc_pkg::ADV_W'(stodc_pkg::DAY_LAST))
                     ? stodc_pkg::DAY_LAST : advance[stodc_pkg::POS_W-1:0];
  assign pos_sum     = {1'b0, position} + {1'b0, advance_sat};
  assign scale_prod  = 49'(position) * 49'(stodc_pkg::SEC_PER_HOUR);

  assign div_in   = (state == stodc_pkg::ST_DIV_SEC) ? total
                  : stodc_pkg::TOTAL_W'(minute_of_day);
  assign div_prod = stodc_pkg::DIV_PROD_W'(div_in) * stodc_pkg::DIV_PROD_W'(stodc_pkg::RECIP_60);
  assign div_q    = div_prod[34:24];
  assign div_q60  = stodc_pkg::TOTAL_W'({div_q, 6'b0}) - stodc_pkg::TOTAL_W'({div_q, 2'b0});
  assign div_rem  = div_in - div_q60;

  assign leap       = (year[1:0] == 2'b00) && ((year_mod100 != 7'd0) || (year_mod400 == 9'd0));
  assign day_sum    = {1'b0, day} + 6'(carry);
  assign month_over = day_sum > {1'b0, stodc_pkg::days_in(month, leap)};
  assign year_step  = month_over && !(month < stodc_pkg::MONTH_LAST) && (year != YEAR_MAX);
  assign event_hit  = (minute != prev_minutes)
                    && ((minute == 6'd0) || (minute == stodc_pkg::MIN_HALF));

  always_ff @(posedge clk) begin
    if (rst) begin
      rate         <= stodc_pkg::RATE_RESET;
      position     <= stodc_pkg::POS_RESET;
      prev_minutes <= stodc_pkg::MIN_RESET;
      day          <= stodc_pkg::DAY_RESET;
      month        <= stodc_pkg::MONTH_RESET;
      year         <= YEAR_RESET;
      year_mod100  <= 7'd2;
      year_mod400  <= 9'd2;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        rate <= cfg_write_data;
      end
      if (state == stodc_pkg::ST_ADD) begin
        if (pos_sum >= {1'b0, stodc_pkg::FULL_DAY}) begin
          position <= stodc_pkg::POS_W'(pos_sum - {1'b0, stodc_pkg::FULL_DAY});
        end else begin
          position <= pos_sum[stodc_pkg::POS_W-1:0];
        end
      end
      if (out_valid && !out_stall && !commit) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        out_valid    <= 1'b1;
        prev_minutes <= minute;
        if (month_over) begin
          day <= 5'd1;
          if (month < stodc_pkg::MONTH_LAST) begin
            month <= month + 4'd1;
          end else begin
            month <= 4'd1;
          end
        end else begin
          day <= day_sum[4:0];
        end
        if (year_step) begin
          year        <= year + YEAR_BITS'(1);
          year_mod100 <= (year_mod100 == stodc_pkg::CENTURY_LAST) ? 7'd0 : year_mod100 + 7'd1;
          year_mod400 <= (year_mod400 == stodc_pkg::QUAD_LAST) ? 9'd0 : year_mod400 + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == stodc_pkg::ST_IDLE && in_valid) begin
      elapsed <= elapsed_time;
    end
    if (state == stodc_pkg::ST_MUL) begin
      product <= stodc_pkg::PROD_W'(elapsed) * stodc_pkg::PROD_W'(rate);
    end
    if (state == stodc_pkg::ST_ADD) begin
      carry <= pos_sum >= {1'b0, stodc_pkg::FULL_DAY};
    end
    if (state == stodc_pkg::ST_SCALE) begin
      total <= scale_prod[48:32];
    end
    if (state == stodc_pkg::ST_DIV_SEC) begin
      second        <= div_rem[5:0];
      minute_of_day <= div_q;
    end
    if (state == stodc_pkg::ST_DIV_MIN) begin
      minute <= div_rem[5:0];
      hour   <= div_q[4:0];
    end
    if (commit) begin
      second_of_minute <= second;
      minute_of_hour   <= minute;
      hour_of_day      <= hour;
      half_hour_event  <= event_hit;
      half_hour_slot   <= event_hit
                        ? ({hour, 1'b0} + 6'(minute == stodc_pkg::MIN_HALF)) : 6'd0;
      day_of_month     <= month_over ? 5'd1 : day_sum[4:0];
      month_of_year    <= month_over ? ((month < stodc_pkg::MONTH_LAST) ? month + 4'd1 : 4'd1)
                        : month;
      year_count       <= 16'(year_step ? year + YEAR_BITS'(1) : year);
    end
  end

endmodule

/* sv/stodc_checker.sv */
// Port-level checks of the time-of-day calendar and their binding to the top level.
`include "scaled_time_of_day_calendar_top_macros.svh"

module stodc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  second_of_minute,
  input logic [5:0]  minute_of_hour,
  input logic [4:0]  hour_of_day,
  input logic [4:0]  day_of_month,
  input logic [3:0]  month_of_year,
  input logic [15:0] year_count,
  input logic        half_hour_event,
  input logic [5:0]  half_hour_slot
);

  logic        slot_ok;
  logic        fields_ok;
  logic [49:0] result_word;

  assign slot_ok     = half_hour_event || (half_hour_slot == 6'd0);
  assign fields_ok   = (second_of_minute < 6'd60) && (minute_of_hour < 6'd60)
                     && (hour_of_day < 5'd24) && (day_of_month != 5'd0)
                     && (month_of_year != 4'd0) && (month_of_year < 4'd13);
  assign result_word = {out_valid, second_of_minute, minute_of_hour, hour_of_day, day_of_month,
                        month_of_year, year_count, half_hour_event, half_hour_slot};

  `STODC_ASSERT(busy_after_transfer, clk, rst, (in_valid && !in_stall) |=> in_stall)
  `STODC_ASSERT(slot_zero_without_event, clk, rst, out_valid |-> slot_ok)
  `STODC_ASSERT(fields_in_range, clk, rst, out_valid |-> fields_ok)
  `STODC_ASSERT_HOLD(result_held, clk, rst, out_valid && out_stall, result_word)

endmodule

bind scaled_time_of_day_calendar_top stodc_checker u_stodc_checker (.*);
